FILE: sv/lrdc_pkg.sv
`default_nettype none

package lrdc_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] MaxLenReset = 32'd65535;

  // input beat command, carried on s_axis_tuser
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_EOS  = 2'd1,
    CMD_STOP = 2'd2,
    CMD_ERR  = 2'd3
  } cmd_e;

  // result kind, carried on m_axis_tuser
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TORN     = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_STOPPED  = 3'd3,
    ST_CONS_ERR = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ENDED   = 3'b100
  } phase_e;

  // every result caused by one input beat, in output order:
  // payload byte, verdict, scan end status
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       has_verdict;
    logic       good;
    logic       has_status;
    status_e    status;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lrdc_front.sv
`default_nettype none

module lrdc_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire  [31:0]          cfg_data_i,
  input  wire                  accept_i,
  input  wire  [1:0]           cmd_i,
  input  wire  [7:0]           byte_i,
  output logic                 ended_o,
  output logic                 push_o,
  output lrdc_pkg::entry_t     entry_o
);
  import lrdc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] stored_q, stored_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] left_q, left_d;
  logic [31:0] max_len_q;
  logic [31:0] crc_next;
  cmd_e        cmd;
  entry_t      ent;

  assign cmd      = cmd_e'(cmd_i);
  assign crc_next = crc_byte(crc_q, byte_i);
  assign ended_o  = (phase_q == PH_ENDED);

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    len_d     = len_q;
    stored_d  = stored_q;
    crc_d     = crc_q;
    left_d    = left_q;
    ent       = '0;

    if (accept_i && phase_q != PH_ENDED) begin
      unique case (cmd)
        CMD_EOS: begin
          ent.has_status = 1'b1;
          ent.status     = (phase_q == PH_PAYLOAD) ? ST_TORN : ST_OK;
          phase_d        = PH_ENDED;
        end
        CMD_STOP: begin
          ent.has_status = 1'b1;
          ent.status     = ST_STOPPED;
          phase_d        = PH_ENDED;
        end
        CMD_ERR: begin
          ent.has_status = 1'b1;
          ent.status     = ST_CONS_ERR;
          phase_d        = PH_ENDED;
        end
        CMD_BYTE: begin
          if (phase_q == PH_HEADER) begin
            // little-endian lanes: bytes 0..3 length, 4..7 stored CRC
            unique case (hdr_cnt_q[1:0])
              2'd0: begin
                if (hdr_cnt_q[2]) stored_d[7:0] = byte_i;
                else              len_d[7:0]    = byte_i;
              end
              2'd1: begin
                if (hdr_cnt_q[2]) stored_d[15:8] = byte_i;
                else              len_d[15:8]    = byte_i;
              end
              2'd2: begin
                if (hdr_cnt_q[2]) stored_d[23:16] = byte_i;
                else              len_d[23:16]    = byte_i;
              end
              default: begin
                if (hdr_cnt_q[2]) stored_d[31:24] = byte_i;
                else              len_d[31:24]    = byte_i;
              end
            endcase
            hdr_cnt_d = hdr_cnt_q + 3'd1;
            if (hdr_cnt_q == 3'd7) begin
              crc_d  = CrcInit;
              left_d = len_q;
              if (len_q > max_len_q) begin
                ent.has_status = 1'b1;
                ent.status     = ST_TOO_LONG;
                phase_d        = PH_ENDED;
              end else if (len_q == 32'd0) begin
                // empty payload: CRC of nothing is zero
                ent.has_verdict = 1'b1;
                ent.good        = (stored_d == 32'd0);
                if (stored_d != 32'd0) begin
                  ent.has_status = 1'b1;
                  ent.status     = ST_CRC_ERR;
                  phase_d        = PH_ENDED;
                end
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end else begin
            ent.has_byte = 1'b1;
            ent.data     = byte_i;
            crc_d        = crc_next;
            left_d       = left_q - 32'd1;
            if (left_q == 32'd1) begin
              ent.has_verdict = 1'b1;
              ent.good        = (~crc_next == stored_q);
              if (~crc_next == stored_q) begin
                phase_d   = PH_HEADER;
                hdr_cnt_d = 3'd0;
                crc_d     = CrcInit;
              end else begin
                ent.has_status = 1'b1;
                ent.status     = ST_CRC_ERR;
                phase_d        = PH_ENDED;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign entry_o = ent;
  assign push_o  = ent.has_byte | ent.has_verdict | ent.has_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= 3'd0;
      len_q     <= 32'd0;
      stored_q  <= 32'd0;
      crc_q     <= CrcInit;
      left_q    <= 32'd0;
      max_len_q <= MaxLenReset;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      stored_q  <= stored_d;
      crc_q     <= crc_d;
      left_q    <= left_d;
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lrdc_queue.sv
`default_nettype none

module lrdc_queue #(
  parameter int unsigned Depth = lrdc_pkg::QueueDepth
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  lrdc_pkg::entry_t  entry_i,
  output logic              full_o,
  input  wire               pop_i,
  output lrdc_pkg::entry_t  entry_o,
  output logic              empty_o
);
  import lrdc_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lrdc_back.sv
`default_nettype none

module lrdc_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  lrdc_pkg::entry_t  entry_i,
  input  wire               empty_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [15:0]       m_axis_tdata,
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  import lrdc_pkg::*;

  entry_t cur_q;
  logic   cur_valid, cur_last, take;
  kind_e  kind;

  assign cur_valid = cur_q.has_byte | cur_q.has_verdict | cur_q.has_status;
  assign cur_last  = ($countones({cur_q.has_byte, cur_q.has_verdict, cur_q.has_status}) == 1);
  assign take      = cur_valid & m_axis_tready;
  assign pop_o     = ~empty_i & (~cur_valid | (take & cur_last));

  always_comb begin
    priority if (cur_q.has_byte) begin
      kind = KIND_PAYLOAD;
    end else if (cur_q.has_verdict) begin
      kind = KIND_VERDICT;
    end else begin
      kind = KIND_STATUS;
    end
  end

  assign m_axis_tvalid = cur_valid;
  assign m_axis_tuser  = kind;
  assign m_axis_tlast  = cur_last;
  assign m_axis_tdata  = {4'd0,
                          (kind == KIND_STATUS)  ? cur_q.status : ST_OK,
                          (kind == KIND_VERDICT) & cur_q.good,
                          (kind == KIND_PAYLOAD) ? cur_q.data : 8'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (pop_o) begin
      cur_q <= entry_i;
    end else if (take) begin
      // retire the result just sent, in order byte, verdict, status
      priority if (cur_q.has_byte) begin
        cur_q.has_byte <= 1'b0;
      end else if (cur_q.has_verdict) begin
        cur_q.has_verdict <= 1'b0;
      end else begin
        cur_q.has_status <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/log_record_deframer_crc_check_core.sv
`default_nettype none

// Log record deframer with CRC-32 check. Takes a byte stream of records, each an
// 8-byte little-endian header (32-bit payload length, then 32-bit stored CRC-32,
// reflected, poly EDB88320) followed by the payload. Payload bytes are passed out
// as they arrive; after the last byte a verdict beat follows. A bad CRC, an
// over-long length (above the cfg register, reset 65535), end of stream, or a
// consumer stop/error ends the scan with a status beat, after which every input
// beat is swallowed until reset. Results leave before the check is done, so the
// consumer has to drop a record whose verdict is bad.
// Rate: one input beat per cycle while the queue has room. The front end parses each
// beat and runs the bytewise CRC on it as it is accepted; the back end sends one result
// per cycle while m_axis_tready is high, so a beat yielding two or three results (last
// payload byte with verdict, bad CRC status) holds the output until all are sent, with a
// QueueDepth-entry queue between the two taking up the slack. No clearing pass after reset.
module log_record_deframer_crc_check_core #(
  parameter int unsigned QueueDepth = lrdc_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // config: max_record_len
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i,
  // input beats
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
  // result beats
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] record_good, [11:9] scan_status
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // final result of its input beat
);
  import lrdc_pkg::*;

  logic   ended, push, full, empty, pop, s_accept;
  entry_t front_entry, queue_entry;

  assign cfg_ready_o   = 1'b1;
  // once the scan has ended beats are dropped, so never stall them
  assign s_axis_tready = ~full | ended;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  lrdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (s_accept),
    .cmd_i       (s_axis_tuser),
    .byte_i      (s_axis_tdata),
    .ended_o     (ended),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  lrdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .empty_o (empty)
  );

  lrdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (queue_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a status beat always closes its input beat's results
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_STATUS) |-> m_axis_tlast)
    else $error("status beat without tlast");

  // a failed verdict must be followed by the CRC error status
  a_bad_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_VERDICT && !m_axis_tdata[8]) |-> !m_axis_tlast)
    else $error("bad verdict not followed by status");

  // a good verdict ends its beat's results
  a_good_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_VERDICT && m_axis_tdata[8]) |-> m_axis_tlast)
    else $error("good verdict without tlast");

  // nothing is queued once the scan has ended
  a_no_push_ended: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended |-> !push)
    else $error("result queued after scan end");

endmodule

`default_nettype wire

FILE: sim/lrdc_deframe_checker.sv
`default_nettype none

package lrdc_tb_pkg;

  // one byte through the reflected CRC-32 register
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    int          k;
    c = crc ^ {24'd0, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ lrdc_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// Watches the config, input and result channels of the deframer, predicts the
// result beats of every accepted input beat and compares them in order.
module lrdc_deframe_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         s_tvalid_i,
  input  wire         s_tready_i,
  input  wire  [7:0]  s_tdata_i,   // [7:0] in_byte
  input  wire  [1:0]  s_tuser_i,   // [1:0] cmd
  input  wire         m_tvalid_i,
  input  wire         m_tready_i,
  input  wire  [15:0] m_tdata_i,   // [7:0] out_byte, [8] record_good, [11:9] scan_status
  input  wire  [1:0]  m_tuser_i,   // [1:0] kind
  input  wire         m_tlast_i,
  output logic [31:0] pending_o,
  output logic [31:0] fails_o,
  output logic [31:0] compared_o
);

  import lrdc_pkg::*;
  import lrdc_tb_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       good;
    status_e    status;
    logic       last;
  } result_t;

  result_t     expected_results[$];
  result_t     beat_res[3];
  int          beat_n;

  phase_e      stage;
  logic [2:0]  hdr_pos;
  logic [31:0] rec_len;
  logic [31:0] crc_stored;
  logic [31:0] crc_run;
  logic [31:0] remaining;
  logic [31:0] max_len;

  int          fails;
  int          compared;

  initial begin
    pending_o  = '0;
    fails_o    = '0;
    compared_o = '0;
    fails      = 0;
    compared   = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic emit(input kind_e k, input logic [7:0] d, input logic g, input status_e s);
    beat_res[beat_n].kind   = k;
    beat_res[beat_n].data   = d;
    beat_res[beat_n].good   = g;
    beat_res[beat_n].status = s;
    beat_res[beat_n].last   = 1'b0;
    beat_n++;
  endtask

  task automatic end_scan(input status_e s);
    stage = PH_ENDED;
    emit(KIND_STATUS, 8'd0, 1'b0, s);
  endtask

  task automatic give_verdict();
    logic good;
    good = (~crc_run == crc_stored);
    emit(KIND_VERDICT, 8'd0, good, ST_OK);
    if (!good) begin
      end_scan(ST_CRC_ERR);
    end else begin
      stage   = PH_HEADER;
      hdr_pos = 3'd0;
      crc_run = CrcInit;
    end
  endtask

  // expected results of one accepted input beat
  task automatic deframe_beat(input cmd_e c, input logic [7:0] b);
    int k;
    beat_n = 0;
    if (stage != PH_ENDED) begin
      case (c)
        CMD_EOS:  end_scan(stage == PH_PAYLOAD ? ST_TORN : ST_OK);
        CMD_STOP: end_scan(ST_STOPPED);
        CMD_ERR:  end_scan(ST_CONS_ERR);
        default: begin
          if (stage == PH_HEADER) begin
            if (hdr_pos < 3'd4) begin
              if (hdr_pos == 3'd0) rec_len = '0;
              rec_len = rec_len | ({24'd0, b} << (8 * hdr_pos[1:0]));
            end else begin
              if (hdr_pos == 3'd4) crc_stored = '0;
              crc_stored = crc_stored | ({24'd0, b} << (8 * hdr_pos[1:0]));
            end
            if (hdr_pos == 3'd7) begin
              hdr_pos   = 3'd0;
              crc_run   = CrcInit;
              remaining = rec_len;
              if (rec_len > max_len) begin
                end_scan(ST_TOO_LONG);
              end else if (rec_len == 32'd0) begin
                give_verdict();
              end else begin
                stage = PH_PAYLOAD;
              end
            end else begin
              hdr_pos = hdr_pos + 3'd1;
            end
          end else begin
            emit(KIND_PAYLOAD, b, 1'b0, ST_OK);
            crc_run   = crc32_update(crc_run, b);
            remaining = remaining - 32'd1;
            if (remaining == 32'd0) give_verdict();
          end
        end
      endcase
    end
    if (beat_n > 0) beat_res[beat_n - 1].last = 1'b1;
    for (k = 0; k < beat_n; k++) expected_results.push_back(beat_res[k]);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected (kind %0d data %h)",
                                m_tuser_i, m_tdata_i));
    end else begin
      want = expected_results.pop_front();
      compared++;
      if (m_tuser_i != want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", m_tuser_i, want.kind));
      if (m_tdata_i[7:0] != want.data)
        report_mismatch($sformatf("out_byte %h, want %h", m_tdata_i[7:0], want.data));
      if (m_tdata_i[8] != want.good)
        report_mismatch($sformatf("record_good %0d, want %0d", m_tdata_i[8], want.good));
      if (m_tdata_i[11:9] != want.status)
        report_mismatch($sformatf("scan_status %0d, want %0d", m_tdata_i[11:9], want.status));
      if (m_tdata_i[15:12] != 4'd0)
        report_mismatch($sformatf("tdata padding %h, want 0", m_tdata_i[15:12]));
      if (m_tlast_i != want.last)
        report_mismatch($sformatf("tlast %0d, want %0d", m_tlast_i, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len    = MaxLenReset;
      stage      = PH_HEADER;
      hdr_pos    = 3'd0;
      rec_len    = '0;
      crc_stored = '0;
      crc_run    = CrcInit;
      remaining  = '0;
      expected_results.delete();
      pending_o <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) max_len = cfg_data_i;
      // predict before comparing, in case a result leaves in its input's cycle
      if (s_tvalid_i && s_tready_i) deframe_beat(cmd_e'(s_tuser_i), s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_result();
      pending_o  <= expected_results.size();
      fails_o    <= fails;
      compared_o <= compared;
    end
  end

endmodule

`default_nettype wire

FILE: sim/log_record_deframer_crc_check_core_tb.sv
`default_nettype none

// Stimulus and verdict for the record deframer. The checker beside the block
// does all prediction and comparison; this module only drives the channels.
module log_record_deframer_crc_check_core_tb;

  import lrdc_pkg::*;
  import lrdc_tb_pkg::*;

  localparam int CycleLimit  = 200000;  // far above the slowest correct run
  localparam int HoldCycles  = 300;     // long output stall, well past the queue depth
  localparam int DrainCycles = 20;      // settle time once nothing is pending
  localparam int IdleCycles  = 8;       // quiet time before a register write
  localparam int IdlePct     = 10;

  // how the single scan of the run is brought to its end
  typedef enum int {
    END_EOS,
    END_STOP,
    END_CONS_ERR,
    END_BAD_CRC,
    END_TOO_LONG
  } ending_e;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tready  = 1'b0;

  wire         cfg_ready;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire  [1:0]  m_tuser;
  wire         m_tlast;

  wire  [31:0] pending;
  wire  [31:0] fails;
  wire  [31:0] compared;

  // pressure controls, set by the sender and read by the receiver
  logic        quiet    = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  int          beats_sent   = 0;
  int          records_sent = 0;
  logic [31:0] limit_now    = MaxLenReset;
  ending_e     ending;

  always #1 clk_i = ~clk_i;

  log_record_deframer_crc_check_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [7:0] in_byte
    .s_axis_tuser  (s_tuser),   // [1:0] cmd
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [7:0] out_byte, [8] record_good, [11:9] scan_status
    .m_axis_tuser  (m_tuser),   // [1:0] kind
    .m_axis_tlast  (m_tlast)
  );

  lrdc_deframe_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .m_tlast_i   (m_tlast),
    .pending_o   (pending),
    .fails_o     (fails),
    .compared_o  (compared)
  );

  // Receiver: random back-pressure, one long hold-off when asked, none while quiet.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Watchdog: a run that hangs or never drains fails here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", CycleLimit, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // One input beat; returns at the edge where it was taken. tvalid stays high
  // into the next beat unless a gap is drawn, so it is never dropped and raised
  // in the same step.
  task automatic send_beat(input cmd_e c, input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= c;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Sender pause until the checker holds nothing. pending is updated at the
  // edge, so the first look is made after the edge that follows the last accepted beat. All
  // phases end on a record boundary, whose final beat always yields a verdict,
  // so an empty queue means the block is idle; IdleCycles more are waited for margin.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  // Header (length, then CRC, little-endian) and payload. stop_after >= 0 cuts
  // the record short after that many beats; corrupt flips one stored CRC bit;
  // extremes fills the payload with alternating 00 / FF.
  task automatic send_record(input logic [31:0] len, input int stop_after,
                             input bit corrupt, input bit extremes);
    logic [7:0]  body[$];
    logic [31:0] crc;
    logic [7:0]  b;
    int          n;
    int          total;
    int          k;
    n   = (len > 32'd1024) ? 0 : int'(len);
    crc = CrcInit;
    for (k = 0; k < n; k++) begin
      b = extremes ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      body.push_back(b);
      crc = crc32_update(crc, b);
    end
    crc = ~crc;
    if (corrupt) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    total = 8 + n;
    if (stop_after >= 0 && stop_after < total) total = stop_after;
    for (k = 0; k < total; k++) begin
      if (k < 4)      b = len[8*k +: 8];
      else if (k < 8) b = crc[8*(k-4) +: 8];
      else            b = body[k-8];
      send_beat(CMD_BYTE, b);
    end
    records_sent++;
  endtask

  task automatic send_records(input int max_pick, input int target);
    while (beats_sent < target) send_record($urandom_range(0, max_pick), -1, 1'b0, 1'b0);
  endtask

  initial begin
    cmd_e        end_cmd;
    logic [31:0] len;
    int          k;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: with a limit of zero only an empty record (CRC of nothing is 0)
    // gets through; with the widest limit, a short payload of extreme bytes.
    write_limit(32'd0);
    send_record(32'd0, -1, 1'b0, 1'b0);
    wait_idle();
    write_limit(32'hFFFF_FFFF);
    send_record(32'd2, -1, 1'b0, 1'b1);
    wait_idle();

    // Small limit; first record sits exactly on it.
    write_limit(32'd4);
    send_record(32'd4, -1, 1'b0, 1'b0);
    send_records(4, 100);
    wait_idle();

    // Reset value written back. Mid-phase the receiver stalls for a long
    // stretch while beats keep coming, so the queue fills and input stalls;
    // later a stretch with no idling on either side.
    write_limit(MaxLenReset);
    send_records(24, 160);
    hold_req <= 1'b1;
    send_records(24, 200);
    quiet <= 1'b1;
    send_records(24, 260);
    quiet <= 1'b0;
    wait_idle();

    // Random limit, then the one scan end this run takes.
    write_limit($urandom_range(8, 40));
    send_records(int'(limit_now), 340);

    ending = ending_e'($urandom_range(0, 4));
    case (ending)
      END_BAD_CRC: begin
        send_record($urandom_range(0, int'(limit_now)), -1, 1'b1, 1'b0);
      end
      END_TOO_LONG: begin
        len = $urandom_range(0, 1) ? limit_now + 32'd1 : 32'hFFFF_FFFF;
        send_record(len, 8, 1'b0, 1'b0);
      end
      default: begin
        // cut anywhere from the record boundary to the last payload byte
        end_cmd = (ending == END_EOS) ? CMD_EOS : (ending == END_STOP) ? CMD_STOP : CMD_ERR;
        len = $urandom_range(1, int'(limit_now));
        send_record(len, $urandom_range(0, 7 + int'(len)), 1'b0, 1'b0);
        send_beat(end_cmd, 8'($urandom_range(0, 255)));
      end
    endcase

    // After the scan has ended every beat must vanish: all commands, then noise.
    for (k = 0; k < 20; k++) begin
      send_beat(k < 4 ? cmd_e'(k) : cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d beats in %0d records across five limit settings; final limit %0d, scan ended by %s.",
             beats_sent, records_sent, limit_now, ending.name());
    $display("Compared %0d result beats, with a long output stall and a stretch without idling.",
             compared);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fails);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: log_record_deframer_crc_check_core.f
sv/lrdc_pkg.sv
sv/lrdc_front.sv
sv/lrdc_queue.sv
sv/lrdc_back.sv
sv/log_record_deframer_crc_check_core.sv
sim/lrdc_deframe_checker.sv
sim/log_record_deframer_crc_check_core_tb.sv
